// File: rtl/largest_free_square_finder_assert.svh
// Assertion macros shared by the largest free square finder RTL.
`ifndef LARGEST_FREE_SQUARE_FINDER_ASSERT_SVH
`define LARGEST_FREE_SQUARE_FINDER_ASSERT_SVH
`ifndef SYNTHESIS
// Checked property, switched off while reset is high.
`define LFSF_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked property that also holds during reset.
`define LFSF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LFSF_ASSERT(lbl, clk, rst, prop, msg)
`define LFSF_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: rtl/lfsf_pkg.sv
// Types and constants shared by the largest free square finder.
`timescale 1ns / 1ps
package lfsf_pkg;

  localparam int CHAR_W     = 8;
  localparam int COUNT_W    = 11;
  localparam int SIZE_W     = 11;
  localparam int POS_W      = 10;
  localparam int REG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [COUNT_W-1:0] ROW_COUNT_RST     = COUNT_W'(1);
  localparam logic [COUNT_W-1:0] COL_COUNT_RST     = COUNT_W'(1);
  localparam logic [CHAR_W-1:0]  OBSTACLE_CHAR_RST = CHAR_W'(111);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROW_COUNT     = 2'd0,
    REG_COL_COUNT     = 2'd1,
    REG_OBSTACLE_CHAR = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [CHAR_W-1:0] cell_char;
  } cell_beat_t;

  typedef struct packed {
    logic [SIZE_W-1:0] square_size;
    logic [POS_W-1:0]  top_row;
    logic [POS_W-1:0]  top_col;
  } result_t;

  typedef struct packed {
    logic [REG_IDX_W-1:0]  reg_index;
    logic [CFG_DATA_W-1:0] wr_data;
  } cfg_beat_t;

endpackage

// File: rtl/lfsf_chan_if.sv
// Valid/ready channel interface used for every port of the finder.
`timescale 1ns / 1ps
interface lfsf_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/lfsf_line_store.sv
// Line store holding the previous row's square sizes, with write-to-read bypass.
`timescale 1ns / 1ps
module lfsf_line_store #(
  parameter int DEPTH = 1024,
  parameter int DW    = 11,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // A read of the entry being written this cycle returns the new value.
  always_ff @(posedge clk) begin
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= wr_data;
    end else begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/largest_free_square_finder.sv
// Largest free square finder: streams grid cells and reports the biggest open square.
//
// Usage. Cells of a grid arrive on the grid channel in raster order, one
// character per beat. Registers row_count (index 0), col_count (index 1)
// and obstacle_char (index 2) are written on the cfg channel, which is
// always ready; write them only while the block is idle. After the last
// cell of a grid, one beat on the result channel carries the side of the
// largest square free of obstacles and its top-left row and column. The
// first strictly larger square found in raster order wins.
// Timing. An accepted cell waits in the input register and is then folded
// into the running state; when the last cell of a grid is folded in, the
// result is loaded into the output register. The line store has one read
// and one write port, and the read for the next column is issued in the
// same cycle as the current write, so cells may arrive back to back at one
// per cycle, unless a grid's last cell must wait for the output register.
// Stalls. The result waits in the output register while new cells keep
// flowing; only a second grid's last cell waits if the first result has
// still not been taken. Reset returns registers to 1, 1 and 111, clears
// the counters and the best square, and leaves the line store as it is.
`timescale 1ns / 1ps
`include "largest_free_square_finder_assert.svh"
module largest_free_square_finder
  import lfsf_pkg::*;
#(
  parameter int MAX_COLS = 1024,
  parameter int MAX_ROWS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  lfsf_chan_if.sink   grid,
  lfsf_chan_if.source result,
  lfsf_chan_if.sink   cfg
);

  // Index widths and widths for count and size arithmetic.
  localparam int CW   = $clog2(MAX_COLS);
  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CCW  = ($clog2(MAX_COLS + 1) > COUNT_W) ? $clog2(MAX_COLS + 1) : COUNT_W;
  localparam int RCW  = ($clog2(MAX_ROWS + 1) > COUNT_W) ? $clog2(MAX_ROWS + 1) : COUNT_W;
  localparam int AW   = ((RW > CW) ? RW : CW) + 1;
  localparam int SCW  = (AW > SIZE_W + 1) ? AW : SIZE_W + 1;

  // Configuration registers. The port never stalls.
  logic [COUNT_W-1:0] row_count;
  logic [COUNT_W-1:0] col_count;
  logic [CHAR_W-1:0]  obstacle_char;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count     <= ROW_COUNT_RST;
      col_count     <= COL_COUNT_RST;
      obstacle_char <= OBSTACLE_CHAR_RST;
    end else if (cfg.valid) begin
      unique case (cfg.data.reg_index)
        REG_ROW_COUNT:     row_count     <= cfg.data.wr_data[COUNT_W-1:0];
        REG_COL_COUNT:     col_count     <= cfg.data.wr_data[COUNT_W-1:0];
        REG_OBSTACLE_CHAR: obstacle_char <= cfg.data.wr_data[CHAR_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective grid dimensions: a zero count acts as one, and a count above
  // the store size acts as the maximum.
  logic [CCW-1:0] col_cnt_ext, cols_eff;
  logic [RCW-1:0] row_cnt_ext, rows_eff;

  always_comb begin
    col_cnt_ext = CCW'(col_count);
    row_cnt_ext = RCW'(row_count);
    if (col_count == '0) begin
      cols_eff = CCW'(1);
    end else if (col_cnt_ext > CCW'(MAX_COLS)) begin
      cols_eff = CCW'(MAX_COLS);
    end else begin
      cols_eff = col_cnt_ext;
    end
    if (row_count == '0) begin
      rows_eff = RCW'(1);
    end else if (row_cnt_ext > RCW'(MAX_ROWS)) begin
      rows_eff = RCW'(MAX_ROWS);
    end else begin
      rows_eff = row_cnt_ext;
    end
  end

  // Input register: one cell waiting to be folded into the state.
  logic              s1_valid;
  logic [CHAR_W-1:0] cell_q;
  logic              s1_adv;
  logic              out_valid;
  result_t           out_data;
  logic              out_free;

  // Running state of the scan.
  logic [SIZE_W-1:0] left_size;
  logic [SIZE_W-1:0] diag_size;
  logic [RW-1:0]     row_index;
  logic [CW-1:0]     col_index;
  logic [SIZE_W-1:0] best_size;
  logic [POS_W-1:0]  best_row;
  logic [POS_W-1:0]  best_col;

  // Line store interface.
  logic [SIZE_W-1:0] up_size;
  logic [CW-1:0]     col_next;
  logic [CW-1:0]     rd_col;

  // Per-cell datapath.
  logic              row_end, grid_end;
  logic              blocked, edge_cell;
  logic [SIZE_W-1:0] min_ud, min_all;
  logic [AW-1:0]     lim;
  logic [SCW-1:0]    grown;
  logic [SIZE_W-1:0] cell_size;
  logic              better;
  logic [SIZE_W-1:0] best_size_upd;
  logic [POS_W-1:0]  best_row_upd;
  logic [POS_W-1:0]  best_col_upd;

  assign out_free   = !out_valid || result.ready;
  // A grid's last cell must have room in the output register to advance.
  assign s1_adv     = s1_valid && (!grid_end || out_free);
  assign grid.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (grid.valid && grid.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (grid.valid && grid.ready) begin
      cell_q <= grid.data.cell_char;
    end
  end

  always_comb begin
    row_end  = (CCW'(col_index) + CCW'(1)) >= cols_eff;
    grid_end = row_end && ((RCW'(row_index) + RCW'(1)) >= rows_eff);
    col_next = row_end ? '0 : CW'(CCW'(col_index) + CCW'(1));
    // Address the column that the next cell will need.
    rd_col   = s1_adv ? col_next : col_index;
  end

  // Square size at the current cell: zero on an obstacle, one on the top
  // row or left column, else one more than the smallest neighbor. The
  // clamp keeps the corner inside the grid even with stale store data.
  always_comb begin
    blocked   = (cell_q == obstacle_char);
    edge_cell = (row_index == '0) || (col_index == '0);
    min_ud    = (up_size < diag_size) ? up_size : diag_size;
    min_all   = (min_ud < left_size) ? min_ud : left_size;
    lim       = ((AW'(row_index) < AW'(col_index)) ? AW'(row_index) : AW'(col_index))
                + AW'(1);
    grown     = SCW'(min_all) + SCW'(1);
    if (blocked) begin
      cell_size = '0;
    end else if (edge_cell) begin
      cell_size = SIZE_W'(1);
    end else if (grown > SCW'(lim)) begin
      cell_size = SIZE_W'(lim);
    end else begin
      cell_size = SIZE_W'(grown);
    end
  end

  always_comb begin
    better        = cell_size > best_size;
    best_size_upd = best_size;
    best_row_upd  = best_row;
    best_col_upd  = best_col;
    if (better) begin
      best_size_upd = cell_size;
      best_row_upd  = POS_W'(SCW'(row_index) + SCW'(1) - SCW'(cell_size));
      best_col_upd  = POS_W'(SCW'(col_index) + SCW'(1) - SCW'(cell_size));
    end
  end

  lfsf_line_store #(
    .DEPTH (MAX_COLS),
    .DW    (SIZE_W),
    .AW    (CW)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (col_index),
    .wr_data (cell_size),
    .rd_addr (rd_col),
    .rd_data (up_size)
  );

  // Scan state update, once per advancing cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_size <= '0;
      diag_size <= '0;
      row_index <= '0;
      col_index <= '0;
      best_size <= '0;
      best_row  <= '0;
      best_col  <= '0;
    end else if (s1_adv) begin
      col_index <= col_next;
      if (row_end) begin
        left_size <= '0;
        diag_size <= '0;
      end else begin
        left_size <= cell_size;
        diag_size <= up_size;
      end
      if (grid_end) begin
        row_index <= '0;
        best_size <= '0;
        best_row  <= '0;
        best_col  <= '0;
      end else begin
        if (row_end) begin
          row_index <= RW'(RCW'(row_index) + RCW'(1));
        end
        best_size <= best_size_upd;
        best_row  <= best_row_upd;
        best_col  <= best_col_upd;
      end
    end
  end

  // Output register: holds one result until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && grid_end) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && grid_end) begin
      out_data.square_size <= best_size_upd;
      out_data.top_row     <= best_row_upd;
      out_data.top_col     <= best_col_upd;
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

  `LFSF_ASSERT(a_result_from_last_cell, clk, rst, $rose(out_valid) |-> $past(s1_adv && grid_end), "result raised without a finished grid")
  `LFSF_ASSERT(a_restart_after_grid, clk, rst, (s1_adv && grid_end) |=> (row_index == '0 && col_index == '0 && best_size == '0), "scan state not restarted after a grid")
  `LFSF_ASSERT(a_size_within_corner, clk, rst, s1_adv |-> (SCW'(cell_size) <= SCW'(lim)), "square size runs past the grid corner")
  `LFSF_ASSERT(a_best_never_shrinks, clk, rst, (s1_adv && !grid_end) |=> (best_size >= $past(best_size)), "best square shrank mid-grid")

endmodule

// File: sim/largest_free_square_checker.sv
// Checker that predicts the largest free square of every grid and compares the result beats.
`timescale 1ns / 1ps
module largest_free_square_checker
  import lfsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cell_valid,
  input  logic       cell_ready,
  input  cell_beat_t cell_beat,
  input  logic       square_valid,
  input  logic       square_ready,
  input  result_t    square_beat,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  cfg_beat_t  cfg_beat,
  output int         pending,
  output int         errors,
  output int         squares_seen
);

  localparam int MAX_COLS = 1024;
  localparam int MAX_ROWS = 1024;

  logic [COUNT_W-1:0] row_count_q;
  logic [COUNT_W-1:0] col_count_q;
  logic [CHAR_W-1:0]  obstacle_q;

  // Square sizes of the row above, indexed by column.
  logic [SIZE_W-1:0]  line_sizes [MAX_COLS];
  logic [SIZE_W-1:0]  left_q;
  logic [SIZE_W-1:0]  diag_q;
  logic [POS_W-1:0]   row_q;
  logic [POS_W-1:0]   col_q;
  logic [SIZE_W-1:0]  best_size_q;
  logic [POS_W-1:0]   best_row_q;
  logic [POS_W-1:0]   best_col_q;

  result_t expected_squares [$];

  initial begin
    foreach (line_sizes[i]) line_sizes[i] = '0;
    pending      = 0;
    errors       = 0;
    squares_seen = 0;
  end

  // A count of zero means one; anything above the store depth saturates.
  function automatic int clamp_count(input logic [COUNT_W-1:0] v, input int limit);
    if (v == '0) return 1;
    if (int'(v) > limit) return limit;
    return int'(v);
  endfunction

  task automatic restart_grid();
    left_q      = '0;
    diag_q      = '0;
    row_q       = '0;
    col_q       = '0;
    best_size_q = '0;
    best_row_q  = '0;
    best_col_q  = '0;
  endtask

  // Folds one cell into the running grid state; the last cell of a grid queues a square.
  task automatic fold_cell(input logic [CHAR_W-1:0] ch);
    int      rows;
    int      cols;
    int      r;
    int      c;
    int      up;
    int      s;
    int      lim;
    result_t sq;
    rows = clamp_count(row_count_q, MAX_ROWS);
    cols = clamp_count(col_count_q, MAX_COLS);
    r    = int'(row_q);
    c    = int'(col_q);
    up   = int'(line_sizes[c]);
    if (ch == obstacle_q) begin
      s = 0;
    end else if (r == 0 || c == 0) begin
      s = 1;
    end else begin
      lim = ((r < c) ? r : c) + 1;
      s = up;
      if (int'(diag_q) < s) s = int'(diag_q);
      if (int'(left_q) < s) s = int'(left_q);
      s = s + 1;
      if (s > lim) s = lim;
    end
    if (s > int'(best_size_q)) begin
      best_size_q = SIZE_W'(s);
      best_row_q  = POS_W'(r + 1 - s);
      best_col_q  = POS_W'(c + 1 - s);
    end
    diag_q        = SIZE_W'(up);
    line_sizes[c] = SIZE_W'(s);
    left_q        = SIZE_W'(s);
    if (c + 1 >= cols) begin
      col_q  = '0;
      left_q = '0;
      diag_q = '0;
      if (r + 1 >= rows) begin
        sq.square_size = best_size_q;
        sq.top_row     = best_row_q;
        sq.top_col     = best_col_q;
        expected_squares.push_back(sq);
        restart_grid();
      end else begin
        row_q = POS_W'(r + 1);
      end
    end else begin
      col_q = POS_W'(c + 1);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      row_count_q = ROW_COUNT_RST;
      col_count_q = COL_COUNT_RST;
      obstacle_q  = OBSTACLE_CHAR_RST;
      restart_grid();
      expected_squares.delete();
    end else begin
      if (square_valid && square_ready) begin
        squares_seen++;
        if (expected_squares.size() == 0) begin
          $error("square beat with no finished grid: size %0d, row %0d, col %0d",
                 square_beat.square_size, square_beat.top_row, square_beat.top_col);
          errors++;
        end else begin
          want = expected_squares.pop_front();
          if (square_beat.square_size !== want.square_size) begin
            $error("square_size mismatch: expected %0d, actual %0d",
                   want.square_size, square_beat.square_size);
            errors++;
          end
          if (square_beat.top_row !== want.top_row) begin
            $error("top_row mismatch: expected %0d, actual %0d",
                   want.top_row, square_beat.top_row);
            errors++;
          end
          if (square_beat.top_col !== want.top_col) begin
            $error("top_col mismatch: expected %0d, actual %0d",
                   want.top_col, square_beat.top_col);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_beat.reg_index)
          REG_ROW_COUNT:     row_count_q = cfg_beat.wr_data[COUNT_W-1:0];
          REG_COL_COUNT:     col_count_q = cfg_beat.wr_data[COUNT_W-1:0];
          REG_OBSTACLE_CHAR: obstacle_q  = cfg_beat.wr_data[CHAR_W-1:0];
          default: ;
        endcase
      end
      if (cell_valid && cell_ready) fold_cell(cell_beat.cell_char);
    end
    pending = expected_squares.size();
  end

endmodule

// File: sim/largest_free_square_finder_test.sv
// Testbench top for the largest free square finder: stimulus, idling and the verdict.
`timescale 1ns / 1ps
module largest_free_square_finder_test;
  import lfsf_pkg::*;

  // The run is cut off here; the slowest correct run stays far below it.
  localparam int CYCLE_LIMIT   = 400000;
  // Length of the one long stretch where results are not taken.
  localparam int PRESSURE_HOLD = 200;
  // Cycles allowed after the last expected square before a register write.
  localparam int SETTLE_CYCLES = 4;
  // Cycles watched after everything has drained, to catch stray beats.
  localparam int DRAIN_CYCLES  = 8;
  localparam int RANDOM_CELLS  = 650;
  localparam int RANDOM_GRIDS  = 40;
  localparam int GRID_MAX      = 1024;
  localparam logic [CHAR_W-1:0] FREE_CELL = 8'h41;

  logic clk = 1'b0;
  logic rst;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  lfsf_chan_if #(.T(cell_beat_t)) grid_ch ();
  lfsf_chan_if #(.T(result_t))    result_ch ();
  lfsf_chan_if #(.T(cfg_beat_t))  cfg_ch ();

  largest_free_square_finder DUT (
    .clk    (clk),
    .rst    (rst),
    .grid   (grid_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  int pending;
  int errors;
  int squares_seen;

  largest_free_square_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cell_valid   (grid_ch.valid),
    .cell_ready   (grid_ch.ready),
    .cell_beat    (grid_ch.data),
    .square_valid (result_ch.valid),
    .square_ready (result_ch.ready),
    .square_beat  (result_ch.data),
    .cfg_valid    (cfg_ch.valid),
    .cfg_ready    (cfg_ch.ready),
    .cfg_beat     (cfg_ch.data),
    .pending      (pending),
    .errors       (errors),
    .squares_seen (squares_seen)
  );

  // Stimulus keeps its own copy of the registers so that it knows how many
  // cells make one grid and which character blocks a cell.
  logic [CFG_DATA_W-1:0] row_setting;
  logic [CFG_DATA_W-1:0] col_setting;
  logic [CHAR_W-1:0]     cur_obstacle;
  int send_mode;
  int cells_sent;
  int grids_sent;
  int writes_done;
  int cycles;

  // Set by the stimulus when the long result stall should happen; the
  // receiving process counts out the stall itself and then marks it done.
  bit pressure_req;
  bit pressure_done;

  // Watchdog: a hang anywhere ends the run as a failure.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("largest_free_square_finder_test failed");
      $finish;
    end
  end

  // Idle cycles before one beat. Mode 0 never idles, mode 1 idles up to the
  // full range on every beat, mode 2 idles only now and then.
  function automatic int pick_gap(input int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 12);
      default: return ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12) : 0;
    endcase
  endfunction

  // Cells per side that the block will actually use for a register value.
  function automatic int grid_dim(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > GRID_MAX) return GRID_MAX;
    return int'(v);
  endfunction

  function automatic logic [CHAR_W-1:0] pick_cell(input int blocked_pct);
    if ($urandom_range(0, 99) < blocked_pct) return cur_obstacle;
    return CHAR_W'($urandom_range(0, 255));
  endfunction

  // Mostly short sides, with the occasional zero that the block treats as one.
  function automatic logic [CFG_DATA_W-1:0] pick_count(input int longest);
    if ($urandom_range(0, 9) == 0) return '0;
    return CFG_DATA_W'($urandom_range(1, longest));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_obstacle();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return CFG_DATA_W'(255);
      default: return CFG_DATA_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int pick_density();
    case ($urandom_range(0, 5))
      0:       return 0;
      1:       return 100;
      2:       return 10;
      3:       return 30;
      default: return $urandom_range(0, 60);
    endcase
  endfunction

  // Every beat task starts and ends at a falling edge. A cell beat leaves
  // valid high, so a following beat with no gap just changes the payload.
  task automatic send_cell(input logic [CHAR_W-1:0] ch);
    int gap;
    gap = pick_gap(send_mode);
    if (gap > 0) begin
      grid_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    grid_ch.valid          <= 1'b1;
    grid_ch.data.cell_char <= ch;
    @(posedge clk);
    while (!grid_ch.ready) @(posedge clk);
    @(negedge clk);
    cells_sent++;
  endtask

  task automatic send_grid(input int blocked_pct);
    int total;
    total = grid_dim(row_setting) * grid_dim(col_setting);
    for (int i = 0; i < total; i++) send_cell(pick_cell(blocked_pct));
    grids_sent++;
  endtask

  // Register writes happen only with the block idle, and valid is dropped
  // again after every write.
  task automatic set_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{reg_index: idx, wr_data: value};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_ROW_COUNT:     row_setting  = value;
      REG_COL_COUNT:     col_setting  = value;
      REG_OBSTACLE_CHAR: cur_obstacle = value[CHAR_W-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  // Stop offering cells and wait until every finished grid has reported.
  task automatic settle();
    grid_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Receiving side: random hold-offs per result beat, stretches with no
  // hold-off at all, and once a long stall that backs the block up.
  initial begin
    int gap;
    int mode;
    int taken;
    result_ch.ready = 1'b0;
    pressure_done   = 1'b0;
    mode  = 0;
    taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken % 8 == 0) mode = $urandom_range(0, 2);
      if (pressure_req && !pressure_done) begin
        result_ch.ready <= 1'b0;
        repeat (PRESSURE_HOLD) @(negedge clk);
        pressure_done = 1'b1;
      end else begin
        gap = pick_gap(mode);
        if (gap > 0) begin
          result_ch.ready <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      result_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(result_ch.valid && result_ch.ready)) @(posedge clk);
      @(negedge clk);
      taken++;
    end
  end

  // Main stimulus: directed grids, the size extremes, the stall, then random grids.
  initial begin
    logic [CHAR_W-1:0] tie_grid    [12];
    logic [CHAR_W-1:0] corner_grid [6];
    int start_cells;
    int start_grids;
    rst           = 1'b1;
    grid_ch.valid = 1'b0;
    grid_ch.data  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    pressure_req  = 1'b0;
    row_setting   = CFG_DATA_W'(ROW_COUNT_RST);
    col_setting   = CFG_DATA_W'(COL_COUNT_RST);
    cur_obstacle  = OBSTACLE_CHAR_RST;
    send_mode     = 2;
    cells_sent    = 0;
    grids_sent    = 0;
    writes_done   = 0;
    // With 0 blocking, the 2 wide square at the top left is found first; the
    // equal square further down must not replace it.
    tie_grid    = '{8'hFF, 8'hFF, 8'hFF, 8'h00,
                    8'hFF, 8'hFF, 8'h00, 8'hFF,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF};
    // With 255 blocking, the first square of size one sits at column 1 and
    // a larger one later takes over with its corner at row 0, column 1.
    corner_grid = '{8'hFF, 8'h00, 8'h00,
                    8'h00, 8'h00, 8'h00};

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings give a one-cell grid blocked by 'o'.
    send_cell(OBSTACLE_CHAR_RST);
    send_cell(8'h00);
    settle();

    // Zero counts act as one.
    set_reg(REG_ROW_COUNT, '0);
    set_reg(REG_COL_COUNT, '0);
    send_cell(8'hFF);
    settle();

    set_reg(REG_OBSTACLE_CHAR, '0);
    set_reg(REG_ROW_COUNT, CFG_DATA_W'(3));
    set_reg(REG_COL_COUNT, CFG_DATA_W'(4));
    foreach (tie_grid[i]) send_cell(tie_grid[i]);
    settle();

    set_reg(REG_OBSTACLE_CHAR, CFG_DATA_W'(255));
    set_reg(REG_ROW_COUNT, CFG_DATA_W'(2));
    set_reg(REG_COL_COUNT, CFG_DATA_W'(3));
    foreach (corner_grid[i]) send_cell(corner_grid[i]);
    settle();

    // One full-width row, with the column count above the maximum, where only
    // the last cell is free: the corner lands on the last column.
    set_reg(REG_OBSTACLE_CHAR, CFG_DATA_W'(8'h5A));
    set_reg(REG_ROW_COUNT, CFG_DATA_W'(1));
    set_reg(REG_COL_COUNT, CFG_DATA_W'(2047));
    for (int i = 0; i < GRID_MAX; i++) send_cell((i == GRID_MAX - 1) ? FREE_CELL : cur_obstacle);
    settle();

    // Same along a full-height column, with the row count at its maximum.
    set_reg(REG_ROW_COUNT, CFG_DATA_W'(GRID_MAX));
    set_reg(REG_COL_COUNT, CFG_DATA_W'(1));
    for (int i = 0; i < GRID_MAX; i++) send_cell((i == GRID_MAX - 1) ? FREE_CELL : cur_obstacle);
    settle();

    // A mostly free square grid lets the sizes grow over several bits.
    set_reg(REG_ROW_COUNT, CFG_DATA_W'(24));
    set_reg(REG_COL_COUNT, CFG_DATA_W'(24));
    send_grid(2);
    send_grid(0);
    settle();

    // Small grids back to back while the receiver stalls: the second
    // finished grid cannot leave, so the block has to hold off its input.
    set_reg(REG_ROW_COUNT, CFG_DATA_W'(2));
    set_reg(REG_COL_COUNT, CFG_DATA_W'(2));
    send_mode    = 0;
    pressure_req = 1'b1;
    repeat (12) send_grid(20);
    settle();

    // Random phases: new settings, then a few grids of random density.
    start_cells = cells_sent;
    start_grids = grids_sent;
    while ((cells_sent - start_cells) < RANDOM_CELLS || (grids_sent - start_grids) < RANDOM_GRIDS) begin
      if ($urandom_range(0, 3) != 0) set_reg(REG_ROW_COUNT, pick_count(6));
      if ($urandom_range(0, 3) != 0) set_reg(REG_COL_COUNT, pick_count(9));
      if ($urandom_range(0, 3) != 0) set_reg(REG_OBSTACLE_CHAR, pick_obstacle());
      send_mode = $urandom_range(0, 2);
      repeat ($urandom_range(2, 6)) send_grid(pick_density());
      settle();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d cells in %0d grids with %0d register writes; %0d squares checked.",
             cells_sent, grids_sent, writes_done, squares_seen);
    $display("Grids ranged from one cell to full-length rows and columns, with one long stall.");
    if (errors == 0 && pending == 0) begin
      $display("largest_free_square_finder_test passed");
    end else begin
      $display("largest_free_square_finder_test failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/lfsf_pkg.sv
rtl/lfsf_chan_if.sv
rtl/lfsf_line_store.sv
rtl/largest_free_square_finder.sv
sim/largest_free_square_checker.sv
sim/largest_free_square_finder_test.sv
